### hw/rtl/evad_pkg.sv
`timescale 1ns / 1ps
package evad_pkg;

  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_BLOCK_END = 2'd1,
    ACT_STOP      = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    RSN_NONE    = 2'd0,
    RSN_SILENCE = 2'd1,
    RSN_MAX_DUR = 2'd2,
    RSN_MANUAL  = 2'd3
  } reason_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_BLOCK_LEN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VOICE_START = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HANGOVER    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_UTT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD   = 3'd4;

  localparam logic [9:0]  BlockLenRst   = 10'd20;
  localparam logic [15:0] VoiceStartRst = 16'd100;
  localparam logic [15:0] HangoverRst   = 16'd800;
  localparam logic [23:0] MaxUttRst     = 24'd15000;
  localparam logic [15:0] ThresholdRst  = 16'd1200;

  localparam int unsigned UttW = 25;
  localparam int unsigned RunW = 17;
  localparam int unsigned LevelW = 7;

  // peak / 300 by reciprocal multiply, exact for peak below the clamp point
  localparam logic [6:0]  LevelCap = 7'd100;
  localparam int unsigned LevelClampPeak = 30000;
  localparam logic [15:0] LevelRecip = 16'd55925;
  localparam int unsigned LevelShift = 24;

  // result tdata layout, lowest bit up
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutLevelLsb = 0;
  localparam int unsigned OutPeakLsb = 7;
  localparam int unsigned OutVoicedBit = 23;
  localparam int unsigned OutSeenBit = 24;
  localparam int unsigned OutStoppedBit = 25;
  localparam int unsigned OutReasonLsb = 26;

  typedef struct packed {
    logic [9:0]  block_len;
    logic [15:0] voice_start;
    logic [15:0] hangover;
    logic [23:0] max_utt;
    logic [15:0] threshold;
  } cfg_t;

endpackage

### hw/rtl/evad_cfg.sv
`timescale 1ns / 1ps
module evad_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [evad_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [evad_pkg::CfgDataW-1:0]   cfg_data_i,
  output evad_pkg::cfg_t                  cfg_o
);
  import evad_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLOCK_LEN:   cfg_d.block_len   = cfg_data_i[9:0];
        REG_VOICE_START: cfg_d.voice_start = cfg_data_i[15:0];
        REG_HANGOVER:    cfg_d.hangover    = cfg_data_i[15:0];
        REG_MAX_UTT:     cfg_d.max_utt     = cfg_data_i[23:0];
        REG_THRESHOLD:   cfg_d.threshold   = cfg_data_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_len   <= BlockLenRst;
      cfg_q.voice_start <= VoiceStartRst;
      cfg_q.hangover    <= HangoverRst;
      cfg_q.max_utt     <= MaxUttRst;
      cfg_q.threshold   <= ThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/energy_vad_endpointer.sv
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata sample, tuser action, tlast block end
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata level, peak, flags, halt cause
// cfg       | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
// one request per cycle on s_axis unless stalled; only block ends and stops give results
// stage 1 registers the action and sample magnitude, stage 2 updates the
// block state and loads the result register in the same cycle
// the state step in stage 2 sets the rate: one request per cycle while not stalled
// m_axis_tready low holds both stages once the result register is full
// reset clears valid flags and block state and loads cfg defaults; cfg is always ready
`timescale 1ns / 1ps
module energy_vad_endpointer #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample
  input  logic [1:0]                            s_axis_tuser,  // action
  input  logic                                  s_axis_tlast,  // block end
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // level, block_peak, voiced, speech_seen, stopped, halt_cause
  output logic [evad_pkg::OutDataW-1:0]         m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [evad_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [evad_pkg::CfgDataW-1:0]         cfg_data_i
);
  import evad_pkg::*;

  localparam int unsigned CmpW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  cfg_t cfg;

  evad_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // stage 1
  logic                   s1_valid_q, s1_valid_d;
  action_e                act_q;
  logic [SAMPLE_BITS-1:0] mag_q, mag_d;
  logic                   last_q;
  logic                   s2_adv;
  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] raw;

  assign raw = s_axis_tdata[SAMPLE_BITS-1:0];
  assign mag_d = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

  assign s2_adv = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s2_adv;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s1_valid_d = in_acc ? 1'b1 : (s2_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_e'(s_axis_tuser);
      mag_q  <= mag_d;
      last_q <= s_axis_tlast;
    end
  end

  // block state
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [UttW-1:0]        utt_q, utt_d;
  logic [RunW-1:0]        run_q, run_d;
  logic [RunW-1:0]        sil_q, sil_d;
  logic [LevelW-1:0]      lvl_q, lvl_d;
  logic                   seen_q, seen_d;
  logic                   stop_q, stop_d;
  reason_e                reason_q, reason_d;

  logic [SAMPLE_BITS-1:0] pk_max, fin_peak;
  logic [CmpW-1:0]        peak_ext;
  logic [30:0]            lvl_prod;
  logic [LevelW-1:0]      lvl_new;
  logic                   voiced;
  logic [UttW:0]          utt_sum;
  logic [RunW:0]          run_sum, sil_sum;
  logic                   finish, manual, emit;

  assign pk_max = (mag_q > peak_q) ? mag_q : peak_q;
  assign fin_peak = (act_q == ACT_SAMPLE) ? pk_max : peak_q;
  assign peak_ext = CmpW'(fin_peak);
  assign lvl_prod = 31'(peak_ext[14:0]) * 31'(LevelRecip);
  assign lvl_new = (peak_ext >= CmpW'(LevelClampPeak)) ? LevelCap
                                                       : lvl_prod[LevelShift +: LevelW];
  assign voiced = peak_ext >= CmpW'(cfg.threshold);
  assign utt_sum = {1'b0, utt_q} + (UttW+1)'(cfg.block_len);
  assign run_sum = {1'b0, run_q} + (RunW+1)'(cfg.block_len);
  assign sil_sum = {1'b0, sil_q} + (RunW+1)'(cfg.block_len);

  always_comb begin
    finish = 1'b0;
    manual = 1'b0;
    if (s2_adv && !stop_q) begin
      case (act_q)
        ACT_SAMPLE:    finish = last_q;
        ACT_BLOCK_END: finish = 1'b1;
        ACT_STOP:      manual = 1'b1;
        default:       finish = 1'b0;
      endcase
    end
  end

  always_comb begin
    peak_d   = peak_q;
    utt_d    = utt_q;
    run_d    = run_q;
    sil_d    = sil_q;
    lvl_d    = lvl_q;
    seen_d   = seen_q;
    stop_d   = stop_q;
    reason_d = reason_q;
    if (s2_adv && !stop_q && act_q == ACT_SAMPLE && !last_q) begin
      peak_d = pk_max;
    end
    if (finish) begin
      peak_d = '0;
      lvl_d  = lvl_new;
      utt_d  = utt_sum[UttW] ? '1 : utt_sum[UttW-1:0];
      if (voiced) begin
        run_d = run_sum[RunW] ? '1 : run_sum[RunW-1:0];
        sil_d = '0;
        if (run_d >= RunW'(cfg.voice_start)) begin
          seen_d = 1'b1;
        end
      end else begin
        run_d = '0;
        sil_d = sil_sum[RunW] ? '1 : sil_sum[RunW-1:0];
      end
      if (seen_d && sil_d >= RunW'(cfg.hangover)) begin
        stop_d   = 1'b1;
        reason_d = RSN_SILENCE;
      end else if (utt_d >= UttW'(cfg.max_utt)) begin
        stop_d   = 1'b1;
        reason_d = RSN_MAX_DUR;
      end
    end
    if (manual) begin
      stop_d   = 1'b1;
      reason_d = RSN_MANUAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q   <= '0;
      utt_q    <= '0;
      run_q    <= '0;
      sil_q    <= '0;
      lvl_q    <= '0;
      seen_q   <= 1'b0;
      stop_q   <= 1'b0;
      reason_q <= RSN_NONE;
    end else begin
      peak_q   <= peak_d;
      utt_q    <= utt_d;
      run_q    <= run_d;
      sil_q    <= sil_d;
      lvl_q    <= lvl_d;
      seen_q   <= seen_d;
      stop_q   <= stop_d;
      reason_q <= reason_d;
    end
  end

  // result register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  assign emit = finish || manual;

  always_comb begin
    out_data_d = '0;
    out_data_d[OutLevelLsb +: LevelW] = lvl_d;
    out_data_d[OutPeakLsb +: 16]      = manual ? 16'd0 : peak_ext[15:0];
    out_data_d[OutVoicedBit]          = manual ? 1'b0 : voiced;
    out_data_d[OutSeenBit]            = seen_d;
    out_data_d[OutStoppedBit]         = stop_d;
    out_data_d[OutReasonLsb +: 2]     = reason_d;
  end

  assign out_valid_d = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### hw/rtl/evad_checker.sv
`timescale 1ns / 1ps
module evad_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [evad_pkg::OutDataW-1:0] m_axis_tdata
);
  import evad_pkg::*;

  logic       stopped;
  logic [1:0] reason;
  logic [6:0] level;

  assign stopped = m_axis_tdata[OutStoppedBit];
  assign reason  = m_axis_tdata[OutReasonLsb +: 2];
  assign level   = m_axis_tdata[OutLevelLsb +: LevelW];

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_stop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && stopped |=> !m_axis_tvalid)
    else $error("result after stop");

  a_reason_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (stopped == (reason != RSN_NONE)))
    else $error("stop flag and reason disagree");

  a_level_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> level <= LevelCap)
    else $error("level above cap");

endmodule

bind energy_vad_endpointer evad_checker u_evad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### test/tb_energy_vad_endpointer.sv
`timescale 1ns / 1ps
module tb_energy_vad_endpointer;
  import evad_pkg::*;

  localparam logic [1:0] ActIgnored = 2'd3;
  localparam int unsigned LevelStep = 300;
  localparam int unsigned UttTop = (1 << UttW) - 1;
  localparam int unsigned RunTop = (1 << RunW) - 1;

  typedef enum int {
    END_MANUAL,
    END_SILENCE,
    END_MAX_DUR,
    END_BOTH
  } finale_e;

  typedef struct {
    logic [1:0]  act;
    logic [15:0] smp;
    logic        last;
  } request_t;

  typedef struct {
    logic [6:0]  level;
    logic [15:0] peak;
    logic        voiced;
    logic        seen;
    logic        stopped;
    reason_e     reason;
  } report_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;   // sample
  logic [1:0]          s_axis_tuser = '0;   // action
  logic                s_axis_tlast = 1'b0; // block end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // level, block_peak, voiced, speech_seen, stopped, halt_cause
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  energy_vad_endpointer dut (.*);

  request_t request_backlog[$];
  report_t  expected_reports[$];
  int       mismatches = 0;

  // block settings and state as the endpointer should hold them
  int unsigned cfg_blk_ms = BlockLenRst;
  int unsigned cfg_start_ms = VoiceStartRst;
  int unsigned cfg_hang_ms = HangoverRst;
  int unsigned cfg_max_ms = MaxUttRst;
  int unsigned cfg_thr = ThresholdRst;
  logic [15:0] st_peak = '0;
  int unsigned st_utt = 0;
  int unsigned st_run = 0;
  int unsigned st_sil = 0;
  logic [6:0]  st_level = '0;
  logic        st_seen = 1'b0;
  logic        st_stopped = 1'b0;
  reason_e     st_reason = RSN_NONE;

  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("energy_vad_endpointer verification failed");
    $finish;
  end

  function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned top);
    return (a + b > top) ? top : a + b;
  endfunction

  function automatic void advance_endpointer(input request_t rq);
    logic [15:0] mag;
    int unsigned pk;
    int unsigned lvl;
    logic        loud;
    if (st_stopped) return;
    if (rq.act == ACT_STOP) begin
      st_stopped = 1'b1;
      st_reason = RSN_MANUAL;
      expected_reports.push_back('{level: st_level, peak: 16'd0, voiced: 1'b0,
                                   seen: st_seen, stopped: 1'b1, reason: RSN_MANUAL});
      return;
    end
    if (rq.act == ActIgnored) return;
    if (rq.act == ACT_SAMPLE) begin
      mag = rq.smp[15] ? ~rq.smp + 16'd1 : rq.smp;
      if (mag > st_peak) st_peak = mag;
      if (!rq.last) return;
    end
    pk = st_peak;
    st_peak = '0;
    lvl = pk / LevelStep;
    st_level = (lvl > LevelCap) ? LevelCap : lvl[6:0];
    loud = (pk >= cfg_thr);
    st_utt = sat_add(st_utt, cfg_blk_ms, UttTop);
    if (loud) begin
      st_run = sat_add(st_run, cfg_blk_ms, RunTop);
      if (st_run >= cfg_start_ms) st_seen = 1'b1;
      st_sil = 0;
    end else begin
      st_run = 0;
      st_sil = sat_add(st_sil, cfg_blk_ms, RunTop);
    end
    if (st_seen && st_sil >= cfg_hang_ms) begin
      st_stopped = 1'b1;
      st_reason = RSN_SILENCE;
    end else if (st_utt >= cfg_max_ms) begin
      st_stopped = 1'b1;
      st_reason = RSN_MAX_DUR;
    end
    expected_reports.push_back('{level: st_level, peak: pk[15:0], voiced: loud,
                                 seen: st_seen, stopped: st_stopped, reason: st_reason});
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // sender: bursts of requests with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) advance_endpointer(request_backlog.pop_front());
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= request_backlog[0].act;
          s_axis_tdata <= request_backlog[0].smp;
          s_axis_tlast <= request_backlog[0].last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results and stalls in changing modes
  always @(posedge clk_i) begin
    report_t want;
    report_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.level = m_axis_tdata[OutLevelLsb +: LevelW];
      got.peak = m_axis_tdata[OutPeakLsb +: 16];
      got.voiced = m_axis_tdata[OutVoicedBit];
      got.seen = m_axis_tdata[OutSeenBit];
      got.stopped = m_axis_tdata[OutStoppedBit];
      got.reason = reason_e'(m_axis_tdata[OutReasonLsb +: 2]);
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("level", want.level, got.level);
        check_field("block_peak", want.peak, got.peak);
        check_field("voiced", want.voiced, got.voiced);
        check_field("speech_seen", want.seen, got.seen);
        check_field("stopped", want.stopped, got.stopped);
        check_field("halt_cause", want.reason, got.reason);
      end
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready <= mode_left[2];
    endcase
  end

  task automatic push_req(input logic [1:0] act, input logic [15:0] smp, input logic last);
    request_backlog.push_back('{act: act, smp: smp, last: last});
  endtask

  function automatic logic [15:0] pick_sample(input bit allow_full);
    logic [15:0] s;
    case ($urandom_range(0, 5))
      0, 1: s = 16'($urandom);
      2: s = 16'(cfg_thr);
      3: s = 16'(cfg_thr - 1);
      4: s = 16'($urandom_range(0, 700));
      default: s = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    endcase
    if ($urandom_range(0, 1)) s = ~s + 16'd1;
    if (!allow_full && s == 16'h8000) s = 16'h7fff;
    return s;
  endfunction

  task automatic queue_random_blocks(input int nblocks, input bit allow_full);
    int len;
    bit open_end;
    for (int b = 0; b < nblocks; b++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(ACT_BLOCK_END, 16'($urandom), 1'($urandom));
      end else begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
        open_end = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 11) == 0) push_req(ActIgnored, 16'($urandom), 1'($urandom));
          push_req(ACT_SAMPLE, pick_sample(allow_full), (i == len - 1) && !open_end);
        end
        if (open_end) push_req(ACT_BLOCK_END, 16'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (request_backlog.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned blk, input int unsigned start,
                           input int unsigned hang, input int unsigned top,
                           input int unsigned thr);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] val [5];
    idx = '{REG_BLOCK_LEN, REG_VOICE_START, REG_HANGOVER, REG_MAX_UTT, REG_THRESHOLD};
    val = '{CfgDataW'(blk), CfgDataW'(start), CfgDataW'(hang), CfgDataW'(top),
            CfgDataW'(thr)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[i])
        REG_BLOCK_LEN:   cfg_blk_ms = val[i][9:0];
        REG_VOICE_START: cfg_start_ms = val[i][15:0];
        REG_HANGOVER:    cfg_hang_ms = val[i][15:0];
        REG_MAX_UTT:     cfg_max_ms = val[i][23:0];
        REG_THRESHOLD:   cfg_thr = val[i][15:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    finale_e     finale;
    int unsigned bl;
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extremes, level clamp, threshold edge, ignored and empty ends
    push_req(ACT_BLOCK_END, 16'hffff, 1'b1);
    push_req(ACT_SAMPLE, 16'h7fff, 1'b0);
    push_req(ACT_SAMPLE, 16'h8000, 1'b1);
    push_req(ACT_SAMPLE, 16'h7fff, 1'b1);
    push_req(ActIgnored, 16'h8000, 1'b1);
    push_req(ACT_SAMPLE, 16'h0000, 1'b1);
    push_req(ACT_SAMPLE, 16'd29999, 1'b1);
    push_req(ACT_SAMPLE, 16'h8ad0, 1'b1);
    push_req(ACT_SAMPLE, 16'd1199, 1'b1);
    push_req(ACT_SAMPLE, 16'hfb50, 1'b1);
    push_req(ACT_SAMPLE, 16'hffff, 1'b0);
    push_req(ACT_SAMPLE, 16'd299, 1'b0);
    push_req(ACT_SAMPLE, 16'd300, 1'b0);
    push_req(ACT_SAMPLE, 16'hfffe, 1'b1);
    push_req(ACT_SAMPLE, 16'hffff, 1'b1);
    push_req(ACT_BLOCK_END, 16'h5a5a, 1'b0);
    push_req(ACT_SAMPLE, 16'h0001, 1'b0);
    push_req(ACT_BLOCK_END, 16'h0000, 1'b0);
    wait_idle();

    // voice start out of reach, so no stop can happen yet
    configure(1023, 65535, 0, 24'hffffff, $urandom_range(1, 32768));
    queue_random_blocks(30, 1'b1);
    wait_idle();
    configure(0, 65535, $urandom_range(0, 65535), 24'hffffff, $urandom_range(1, 65535));
    queue_random_blocks(30, 1'b1);
    wait_idle();
    configure($urandom_range(1, 1000), 65535, $urandom_range(0, 65535), 24'hffffff, 65535);
    queue_random_blocks(30, 1'b1);
    wait_idle();

    // reach voice seen, then force it with full scale blocks
    bl = $urandom_range(1, 50);
    configure(bl, bl * $urandom_range(0, 8), 65535, 24'hffffff, $urandom_range(1, 32768));
    queue_random_blocks(30, 1'b1);
    wait_idle();
    while (!st_seen) begin
      push_req(ACT_SAMPLE, 16'h8000, 1'b1);
      wait_idle();
    end

    // voice seen, hangover out of reach
    configure($urandom_range(1, 50), $urandom_range(0, 65535), 65535, 24'hffffff, 0);
    queue_random_blocks(35, 1'b1);
    wait_idle();
    configure(1, 0, 65535, 24'hffffff, $urandom_range(1, 4000));
    queue_random_blocks(35, 1'b1);
    wait_idle();
    configure($urandom_range(2, 50), 65535, 65535, 24'hffffff, $urandom_range(1, 32768));
    queue_random_blocks(35, 1'b1);
    wait_idle();

    // end of utterance: one finale picked per run (manual, silence, max duration or both), then input is ignored
    finale = finale_e'($urandom_range(0, 3));
    bl = $urandom_range(1, 40);
    n = $urandom_range(1, 6);
    configure(bl, 100, 65535, 24'hffffff, 32768);
    push_req(ACT_SAMPLE, 16'h8000, 1'b1);
    wait_idle();
    if (finale == END_MANUAL) begin
      queue_random_blocks(n, 1'b1);
      push_req(ACT_STOP, 16'($urandom), 1'($urandom));
    end else begin
      configure(bl, 100, (finale != END_MAX_DUR) ? n * bl : 65535,
                (finale != END_SILENCE) ? st_utt + n * bl : 24'hffffff, 32768);
      queue_random_blocks(n + 3, 1'b0);
    end
    for (int i = 0; i < 4; i++) push_req(2'($urandom), 16'($urandom), 1'($urandom));
    push_req(ACT_STOP, 16'($urandom), 1'b1);
    push_req(ACT_SAMPLE, 16'h8000, 1'b1);
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("energy_vad_endpointer verification clean");
    end else begin
      $display("energy_vad_endpointer verification failed");
    end
    $finish;
  end

endmodule
